@@ hdl/nid_pkg.sv @@
package nid_pkg;

   // register stages around the divide steps: operand prep, restore add, sign fix-up
   localparam int unsigned EXTRA_STAGES = 3;

   // control that travels with each request down the pipeline
   typedef struct packed {
      logic valid;
      logic neg_quot;
      logic neg_rem;
      logic div_by_zero;
      logic signed_overflow;
   } ctl_type;

endpackage

@@ hdl/nonrestoring_int_divider.sv @@
// Pipelined non-restoring integer divider, signed or unsigned per request.
// A request is taken whenever start is high; busy is never raised, so one
// request can enter in every cycle. Each result appears on the rsp_ ports
// for one cycle with rsp_valid. On its way each request passes through a
// register for operand magnitudes, one register stage per quotient bit,
// then a register for the restoring add and a final register for the sign
// fix-up. Results come out in request order and the receiver cannot stall
// them, so it must take each one as it appears. Divide by zero returns an
// all-ones quotient and the dividend as remainder; signed -2^(N-1) / -1
// returns -2^(N-1) with remainder 0. Both cases are flagged.
module nonrestoring_int_divider #(
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [DATA_WIDTH-1:0] req_dividend,
   input  logic [DATA_WIDTH-1:0] req_divisor,
   input  logic                  req_is_signed,
   output logic                  rsp_valid,
   output logic [DATA_WIDTH-1:0] rsp_quotient,
   output logic [DATA_WIDTH-1:0] rsp_remainder,
   output logic                  rsp_div_by_zero,
   output logic                  rsp_signed_overflow
);

   localparam int unsigned LATENCY = DATA_WIDTH + nid_pkg::EXTRA_STAGES;

   nid_pkg::ctl_type        ctl_s     [0:DATA_WIDTH];
   logic [DATA_WIDTH:0]     part_s    [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0]   quot_s    [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0]   divisor_s [0:DATA_WIDTH];

   // the pipeline never stalls
   assign busy = 1'b0;

   // operand preparation
   nid_prep #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_prep (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (start && !busy),
      .dividend    (req_dividend),
      .divisor     (req_divisor),
      .is_signed   (req_is_signed),
      .ctl_out     (ctl_s[0]),
      .dividend_mag(quot_s[0]),
      .divisor_mag (divisor_s[0])
   );

   assign part_s[0] = '0;

   // one stage per quotient bit
   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_step
      nid_step #(
         .DATA_WIDTH(DATA_WIDTH)
      ) u_step (
         .clock       (clock),
         .reset       (reset),
         .ctl_prev    (ctl_s[i]),
         .part_prev   (part_s[i]),
         .quot_prev   (quot_s[i]),
         .divisor_prev(divisor_s[i]),
         .ctl_next    (ctl_s[i+1]),
         .part_next   (part_s[i+1]),
         .quot_next   (quot_s[i+1]),
         .divisor_next(divisor_s[i+1])
      );
   end

   // restore and sign fix-up
   nid_post #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_post (
      .clock              (clock),
      .reset              (reset),
      .ctl_prev           (ctl_s[DATA_WIDTH]),
      .part_prev          (part_s[DATA_WIDTH]),
      .quot_prev          (quot_s[DATA_WIDTH]),
      .divisor_prev       (divisor_s[DATA_WIDTH]),
      .res_valid          (rsp_valid),
      .res_quotient       (rsp_quotient),
      .res_remainder      (rsp_remainder),
      .res_div_by_zero    (rsp_div_by_zero),
      .res_signed_overflow(rsp_signed_overflow)
   );

   // both special cases cannot hold for one request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_div_by_zero && rsp_signed_overflow))
      else $error("div_by_zero and signed_overflow both set");

   // divide by zero must give an all-ones quotient
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_by_zero) |-> (&rsp_quotient))
      else $error("divide by zero quotient not all ones");

   // overflow must give the most negative quotient and zero remainder
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_signed_overflow) |->
         (rsp_quotient == {1'b1, {(DATA_WIDTH-1){1'b0}}}) && (rsp_remainder == '0))
      else $error("signed overflow result wrong");

   // a valid request entering the divide steps always comes out of the last step
   assert property (@(posedge clock) disable iff (reset)
      ctl_s[0].valid |-> ##(DATA_WIDTH) ctl_s[DATA_WIDTH].valid)
      else $error("request lost in divide stages");

   // results carry flags only while valid
   assert property (@(posedge clock) disable iff (reset)
      (rsp_div_by_zero || rsp_signed_overflow) |-> rsp_valid)
      else $error("flag without result strobe");

   // every accepted request returns its result after the full pipeline depth
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(LATENCY) rsp_valid)
      else $error("latency mismatch");

endmodule

@@ hdl/nid_prep.sv @@
module nid_prep #(
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [DATA_WIDTH-1:0] dividend,
   input  logic [DATA_WIDTH-1:0] divisor,
   input  logic                  is_signed,
   output nid_pkg::ctl_type      ctl_out,
   output logic [DATA_WIDTH-1:0] dividend_mag,
   output logic [DATA_WIDTH-1:0] divisor_mag
);

   localparam logic [DATA_WIDTH-1:0] MIN_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   nid_pkg::ctl_type        ctl_in, ctl_ff;
   logic [DATA_WIDTH-1:0]   dividend_in, dividend_ff;
   logic [DATA_WIDTH-1:0]   divisor_in, divisor_ff;
   logic                    neg_dividend, neg_divisor;

   // special cases and operand signs, flags only raised for a real request
   // a zero divisor keeps the raw dividend so the steps return it as remainder
   always_comb begin
      ctl_in.valid           = req_valid;
      ctl_in.div_by_zero     = req_valid && (divisor == '0);
      ctl_in.signed_overflow = req_valid && is_signed && (dividend == MIN_NEG) && (&divisor);
      neg_dividend           = is_signed && dividend[DATA_WIDTH-1] && !ctl_in.div_by_zero;
      neg_divisor            = is_signed && divisor[DATA_WIDTH-1];
      ctl_in.neg_quot        = neg_dividend ^ neg_divisor;
      ctl_in.neg_rem         = neg_dividend;
      dividend_in            = neg_dividend ? (~dividend + 1'b1) : dividend;
      divisor_in             = neg_divisor ? (~divisor + 1'b1) : divisor;
   end

   // control register
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   // operand magnitudes
   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
   end

   assign ctl_out      = ctl_ff;
   assign dividend_mag = dividend_ff;
   assign divisor_mag  = divisor_ff;

endmodule

@@ hdl/nid_step.sv @@
module nid_step #(
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  nid_pkg::ctl_type      ctl_prev,
   input  logic [DATA_WIDTH:0]   part_prev,
   input  logic [DATA_WIDTH-1:0] quot_prev,
   input  logic [DATA_WIDTH-1:0] divisor_prev,
   output nid_pkg::ctl_type      ctl_next,
   output logic [DATA_WIDTH:0]   part_next,
   output logic [DATA_WIDTH-1:0] quot_next,
   output logic [DATA_WIDTH-1:0] divisor_next
);

   nid_pkg::ctl_type        ctl_ff;
   logic [DATA_WIDTH:0]     part_in, part_ff;
   logic [DATA_WIDTH:0]     shifted;
   logic [DATA_WIDTH-1:0]   quot_in, quot_ff;
   logic [DATA_WIDTH-1:0]   divisor_ff;

   // one non-restoring step: shift in the next dividend bit, then add or subtract
   always_comb begin
      shifted = {part_prev[DATA_WIDTH-1:0], quot_prev[DATA_WIDTH-1]};
      if (part_prev[DATA_WIDTH]) begin
         part_in = shifted + {1'b0, divisor_prev};
      end else begin
         part_in = shifted - {1'b0, divisor_prev};
      end
      quot_in = {quot_prev[DATA_WIDTH-2:0], ~part_in[DATA_WIDTH]};
   end

   // control register
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_prev;
      end
   end

   // data registers
   always_ff @(posedge clock) begin
      part_ff    <= part_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_prev;
   end

   assign ctl_next     = ctl_ff;
   assign part_next    = part_ff;
   assign quot_next    = quot_ff;
   assign divisor_next = divisor_ff;

endmodule

@@ hdl/nid_post.sv @@
module nid_post #(
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  nid_pkg::ctl_type      ctl_prev,
   input  logic [DATA_WIDTH:0]   part_prev,
   input  logic [DATA_WIDTH-1:0] quot_prev,
   input  logic [DATA_WIDTH-1:0] divisor_prev,
   output logic                  res_valid,
   output logic [DATA_WIDTH-1:0] res_quotient,
   output logic [DATA_WIDTH-1:0] res_remainder,
   output logic                  res_div_by_zero,
   output logic                  res_signed_overflow
);

   nid_pkg::ctl_type        ctl_a_ff, ctl_b_ff;
   logic [DATA_WIDTH-1:0]   rem_a_in, rem_a_ff, quot_a_ff;
   logic [DATA_WIDTH-1:0]   rem_b_in, rem_b_ff, quot_b_in, quot_b_ff;

   // restoring add when the partial remainder ended negative
   always_comb begin
      if (part_prev[DATA_WIDTH]) begin
         rem_a_in = part_prev[DATA_WIDTH-1:0] + divisor_prev;
      end else begin
         rem_a_in = part_prev[DATA_WIDTH-1:0];
      end
   end

   // sign fix-up of quotient and remainder
   always_comb begin
      quot_b_in = ctl_a_ff.neg_quot ? (~quot_a_ff + 1'b1) : quot_a_ff;
      rem_b_in  = ctl_a_ff.neg_rem ? (~rem_a_ff + 1'b1) : rem_a_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
      end else begin
         ctl_a_ff <= ctl_prev;
         ctl_b_ff <= ctl_a_ff;
      end
   end

   // data registers
   always_ff @(posedge clock) begin
      rem_a_ff  <= rem_a_in;
      quot_a_ff <= quot_prev;
      rem_b_ff  <= rem_b_in;
      quot_b_ff <= quot_b_in;
   end

   assign res_valid           = ctl_b_ff.valid;
   assign res_quotient        = quot_b_ff;
   assign res_remainder       = rem_b_ff;
   assign res_div_by_zero     = ctl_b_ff.div_by_zero;
   assign res_signed_overflow = ctl_b_ff.signed_overflow;

endmodule

@@ tb/tb_nonrestoring_int_divider.sv @@
`timescale 1ns / 1ps

module tb_nonrestoring_int_divider;

   localparam int W = 32;
   localparam logic [W-1:0] MOST_NEGATIVE = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] ALL_ONES = {W{1'b1}};
   localparam logic SIGNED_MODE = 1'b1;
   localparam logic UNSIGNED_MODE = 1'b0;
   localparam int RANDOM_REQUESTS = 1880;
   localparam int IDLE_LIMIT = 500;
   localparam int SETTLE_CYCLES = W + 8;

   typedef struct packed {
      logic [W-1:0] quotient;
      logic [W-1:0] remainder;
      logic         div_by_zero;
      logic         signed_overflow;
   } div_result_type;

   // one row of the directed table; known marks a typed-in answer
   typedef struct packed {
      logic [W-1:0]   dividend;
      logic [W-1:0]   divisor;
      logic           is_signed;
      logic           known;
      div_result_type answer;
   } div_row_type;

   localparam int DIRECTED_ROWS = 24;
   localparam div_row_type DIRECTED[DIRECTED_ROWS] = '{
      // divide by zero in both modes
      '{32'h0000_0000, 32'h0000_0000, UNSIGNED_MODE, 1'b1,
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0}},
      '{32'hFFFF_FFFF, 32'h0000_0000, SIGNED_MODE, 1'b1,
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0}},
      '{32'h1234_5678, 32'h0000_0000, UNSIGNED_MODE, 1'b1,
        '{32'hFFFF_FFFF, 32'h1234_5678, 1'b1, 1'b0}},
      '{32'h8000_0000, 32'h0000_0000, SIGNED_MODE, 1'b1,
        '{32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 1'b0}},
      // signed overflow, and the same pattern unsigned
      '{32'h8000_0000, 32'hFFFF_FFFF, SIGNED_MODE, 1'b1,
        '{32'h8000_0000, 32'h0000_0000, 1'b0, 1'b1}},
      '{32'h8000_0000, 32'hFFFF_FFFF, UNSIGNED_MODE, 1'b1,
        '{32'h0000_0000, 32'h8000_0000, 1'b0, 1'b0}},
      // extremes of the operands
      '{32'hFFFF_FFFF, 32'h0000_0001, UNSIGNED_MODE, 1'b1,
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0}},
      '{32'hFFFF_FFFF, 32'h0000_0001, SIGNED_MODE, 1'b1,
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0}},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, UNSIGNED_MODE, 1'b1,
        '{32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0}},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, SIGNED_MODE, 1'b1,
        '{32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0}},
      '{32'h0000_0000, 32'hFFFF_FFFF, SIGNED_MODE, 1'b1,
        '{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0}},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, SIGNED_MODE, 1'b1,
        '{32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0}},
      '{32'h8000_0000, 32'h0000_0001, SIGNED_MODE, 1'b1,
        '{32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0}},
      // sign combinations and near misses, checked by the predictor
      '{32'h0000_0007, 32'h0000_0002, SIGNED_MODE, 1'b0, '0},
      '{32'hFFFF_FFF9, 32'h0000_0002, SIGNED_MODE, 1'b0, '0},
      '{32'h0000_0007, 32'hFFFF_FFFE, SIGNED_MODE, 1'b0, '0},
      '{32'hFFFF_FFF9, 32'hFFFF_FFFE, SIGNED_MODE, 1'b0, '0},
      '{32'hFFFF_FFF9, 32'h0000_0002, UNSIGNED_MODE, 1'b0, '0},
      '{32'h7FFF_FFFF, 32'hFFFF_FFFF, SIGNED_MODE, 1'b0, '0},
      '{32'h8000_0000, 32'h0000_0002, SIGNED_MODE, 1'b0, '0},
      '{32'h0000_0005, 32'h0000_0007, UNSIGNED_MODE, 1'b0, '0},
      '{32'hDEAD_BEEF, 32'h0001_2345, UNSIGNED_MODE, 1'b0, '0},
      '{32'hDEAD_BEEF, 32'h8000_0000, SIGNED_MODE, 1'b0, '0},
      '{32'h8000_0001, 32'hFFFF_FFFF, SIGNED_MODE, 1'b0, '0}
   };

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   logic [W-1:0] req_dividend = '0;
   logic [W-1:0] req_divisor = '0;
   logic         req_is_signed = 1'b0;
   logic         rsp_valid;
   logic [W-1:0] rsp_quotient;
   logic [W-1:0] rsp_remainder;
   logic         rsp_div_by_zero;
   logic         rsp_signed_overflow;

   div_result_type pending_results[$];
   div_row_type    typed_answers[$];
   int             mismatch_count = 0;
   int             idle_cycles = 0;

   nonrestoring_int_divider #(
      .DATA_WIDTH(W)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_dividend       (req_dividend),
      .req_divisor        (req_divisor),
      .req_is_signed      (req_is_signed),
      .rsp_valid          (rsp_valid),
      .rsp_quotient       (rsp_quotient),
      .rsp_remainder      (rsp_remainder),
      .rsp_div_by_zero    (rsp_div_by_zero),
      .rsp_signed_overflow(rsp_signed_overflow)
   );

   always #5 clock = ~clock;

   // quotient truncated toward zero, remainder signed like the dividend
   function automatic div_result_type divide_operands(logic [W-1:0] dividend,
                                                      logic [W-1:0] divisor,
                                                      logic sgn);
      div_result_type res;
      logic           neg_dividend;
      logic           neg_divisor;
      logic [W-1:0]   mag_dividend;
      logic [W-1:0]   mag_divisor;
      logic [W-1:0]   mag_quotient;
      logic [W-1:0]   mag_remainder;
      res = '0;
      neg_dividend = sgn & dividend[W-1];
      neg_divisor = sgn & divisor[W-1];
      if (divisor == '0) begin
         res.quotient = ALL_ONES;
         res.remainder = dividend;
         res.div_by_zero = 1'b1;
      end else if (sgn && dividend == MOST_NEGATIVE && divisor == ALL_ONES) begin
         res.quotient = MOST_NEGATIVE;
         res.signed_overflow = 1'b1;
      end else begin
         mag_dividend = neg_dividend ? -dividend : dividend;
         mag_divisor = neg_divisor ? -divisor : divisor;
         mag_quotient = mag_dividend / mag_divisor;
         mag_remainder = mag_dividend % mag_divisor;
         res.quotient = (neg_dividend != neg_divisor) ? -mag_quotient : mag_quotient;
         res.remainder = neg_dividend ? -mag_remainder : mag_remainder;
      end
      return res;
   endfunction

   // operands biased towards sign boundaries, small values and powers of two
   function automatic logic [W-1:0] pick_operand();
      logic [W-1:0] value;
      case ($urandom_range(0, 7))
         0: value = $urandom_range(0, 15);
         1: value = -$urandom_range(1, 16);
         2: value = MOST_NEGATIVE + $urandom_range(0, 3);
         3: value = (MOST_NEGATIVE - 1) - $urandom_range(0, 3);
         4: value = 1 << $urandom_range(0, W - 1);
         5: value = $urandom >> $urandom_range(0, W - 1);
         default: value = $urandom;
      endcase
      return value;
   endfunction

   // accept requests, record expectations and check each result in order
   always @(posedge clock) begin
      div_result_type answer;
      div_result_type seen;
      div_row_type    row;
      if (!reset && start && !busy) begin
         row = typed_answers.pop_front();
         if (row.known)
            answer = row.answer;
         else
            answer = divide_operands(req_dividend, req_divisor, req_is_signed);
         pending_results.push_back(answer);
      end
      if (!reset && rsp_valid) begin
         seen = '{rsp_quotient, rsp_remainder, rsp_div_by_zero, rsp_signed_overflow};
         if (pending_results.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected result: q=%h r=%h dbz=%b ovf=%b",
                        seen.quotient, seen.remainder, seen.div_by_zero,
                        seen.signed_overflow);
            mismatch_count++;
         end else begin
            answer = pending_results.pop_front();
            if (seen !== answer) begin
               if (mismatch_count < 10)
                  $display("mismatch: expected q=%h r=%h dbz=%b ovf=%b, got q=%h r=%h dbz=%b ovf=%b",
                           answer.quotient, answer.remainder, answer.div_by_zero,
                           answer.signed_overflow, seen.quotient, seen.remainder,
                           seen.div_by_zero, seen.signed_overflow);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles where nothing moves in either direction
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[nonrestoring_int_divider] ERROR");
         $finish;
      end
   end

   // present one request after a gap and hold it until it is taken
   task automatic send_request(div_row_type row, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_dividend <= row.dividend;
      req_divisor <= row.divisor;
      req_is_signed <= row.is_signed;
      typed_answers.push_back(row);
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // hold off until every outstanding result has come back
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      div_row_type row;
      int          gap_max;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (DIRECTED[i])
         send_request(DIRECTED[i], $urandom_range(0, 6));
      drain_results();

      // random requests in phases of differing idle density
      gap_max = 6;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 100 == 0) begin
            case ($urandom_range(0, 2))
               0: gap_max = 0;
               1: gap_max = 2;
               default: gap_max = 6;
            endcase
         end
         if ($urandom_range(0, 199) == 0)
            drain_results();
         row = '0;
         case ($urandom_range(0, 19))
            0: begin
               row.dividend = MOST_NEGATIVE;
               row.divisor = ALL_ONES;
               row.is_signed = SIGNED_MODE;
            end
            1: begin
               row.dividend = pick_operand();
               row.divisor = '0;
               row.is_signed = $urandom_range(0, 1);
            end
            default: begin
               row.dividend = pick_operand();
               row.divisor = pick_operand();
               row.is_signed = $urandom_range(0, 1);
            end
         endcase
         send_request(row, $urandom_range(0, gap_max));
      end

      // let the pipeline empty, then watch for stray results
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("[nonrestoring_int_divider] OK");
      else
         $display("[nonrestoring_int_divider] ERROR");
      $finish;
   end

endmodule

@@ sim.f @@
hdl/nid_pkg.sv
hdl/nid_prep.sv
hdl/nid_step.sv
hdl/nid_post.sv
hdl/nonrestoring_int_divider.sv
tb/tb_nonrestoring_int_divider.sv
